>>> hw/rtl/pcbd_pkg.sv
package pcbd_pkg;

    // Table and code geometry.
    localparam int TABLE_SLOTS  = 256;
    localparam int MAX_CODE_LEN = 32;

    // Fixed field widths of a beat.
    localparam int INDEX_W = 8;
    localparam int CODE_W  = 32;
    localparam int ELEN_W  = 6;
    localparam int SYM_W   = 8;

    localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int PLEN_W = $clog2(MAX_CODE_LEN + 1);
    localparam int LCMP_W = (PLEN_W > ELEN_W) ? PLEN_W : ELEN_W;
    localparam int CMP_W  = (MAX_CODE_LEN > CODE_W) ? MAX_CODE_LEN : CODE_W;

    // Match vector is split into groups for the two-level priority pick.
    localparam int GROUP_SIZE = 16;
    localparam int NUM_GROUPS = (TABLE_SLOTS + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int SLOTS_PAD  = NUM_GROUPS * GROUP_SIZE;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_DECODE = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef struct packed {
        logic              write;
        logic              clear;
        logic [SLOT_W-1:0] addr;
        logic [CMP_W-1:0]  code;
        logic [ELEN_W-1:0] length;
        logic [SYM_W-1:0]  symbol;
        logic              used;
    } table_wr_t;

    typedef struct packed {
        logic valid;
        logic overflow;
    } res_ctl_t;

endpackage

>>> hw/rtl/prefix_code_bit_decoder_unit.sv
// Channel | Direction | Handshake            | Payload
// in      | sink      | in_valid / in_stall   | opcode, slot_index, entry_code, entry_length,
//         |           |                       | entry_symbol, entry_valid, bit_value
// out     | source    | out_valid / out_stall | symbol, status
//
// One beat is taken every cycle while out_stall does not hold the pipe; a result passes the
// input register, the group pick register and the output register in that order before it shows on out.
// The prefix and table for a beat are updated together as it leaves the input register;
// the path is set by the 256-slot parallel compare and the hit OR that feeds the prefix register.
// Reset clears the slot used bits, the prefix and all valid flags; slot contents are not cleared.
// out_stall holds all three stages; in_stall rises only with a full input register.
module prefix_code_bit_decoder_unit
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     opcode,
    input  logic [pcbd_pkg::INDEX_W-1:0]   slot_index,
    input  logic [pcbd_pkg::CODE_W-1:0]    entry_code,
    input  logic [pcbd_pkg::ELEN_W-1:0]    entry_length,
    input  logic [pcbd_pkg::SYM_W-1:0]     entry_symbol,
    input  logic                           entry_valid,
    input  logic                           bit_value,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [pcbd_pkg::SYM_W-1:0]     symbol,
    output logic                           status
);

    logic                                 advance;
    logic                                 in_take;
    logic                                 fire;

    logic                                 s1_valid_reg;
    logic [1:0]                           s1_opcode_reg;
    logic [pcbd_pkg::INDEX_W-1:0]         s1_slot_index_reg;
    logic [pcbd_pkg::CODE_W-1:0]          s1_entry_code_reg;
    logic [pcbd_pkg::ELEN_W-1:0]          s1_entry_length_reg;
    logic [pcbd_pkg::SYM_W-1:0]           s1_entry_symbol_reg;
    logic                                 s1_entry_valid_reg;
    logic                                 s1_bit_value_reg;

    logic [pcbd_pkg::MAX_CODE_LEN-1:0]    prefix_bits_reg;
    logic [pcbd_pkg::MAX_CODE_LEN-1:0]    prefix_bits_next;
    logic [pcbd_pkg::PLEN_W-1:0]          prefix_len_reg;
    logic [pcbd_pkg::PLEN_W-1:0]          prefix_len_next;
    logic [pcbd_pkg::MAX_CODE_LEN-1:0]    grown_bits;
    logic [pcbd_pkg::PLEN_W-1:0]          grown_len;

    logic                                 is_write;
    logic                                 is_decode;
    logic                                 is_clear;
    logic                                 in_range;
    logic                                 hit;
    logic                                 overflow;

    pcbd_pkg::table_wr_t                  wr;
    pcbd_pkg::res_ctl_t                   ctl;
    logic [pcbd_pkg::SLOTS_PAD-1:0]       match;
    logic [pcbd_pkg::SLOTS_PAD-1:0][pcbd_pkg::SYM_W-1:0] slot_sym;

    // The whole pipe moves unless a finished result is held at the output.
    assign advance  = !out_valid || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;
    assign fire     = s1_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_opcode_reg       <= opcode;
            s1_slot_index_reg   <= slot_index;
            s1_entry_code_reg   <= entry_code;
            s1_entry_length_reg <= entry_length;
            s1_entry_symbol_reg <= entry_symbol;
            s1_entry_valid_reg  <= entry_valid;
            s1_bit_value_reg    <= bit_value;
        end
    end

    always_comb
    begin
        is_write  = 1'b0;
        is_decode = 1'b0;
        is_clear  = 1'b0;
        unique case (s1_opcode_reg)
            pcbd_pkg::OP_WRITE:  is_write  = 1'b1;
            pcbd_pkg::OP_DECODE: is_decode = 1'b1;
            pcbd_pkg::OP_CLEAR:  is_clear  = 1'b1;
            default:             ;
        endcase
    end

    assign in_range   = int'(s1_slot_index_reg) < pcbd_pkg::TABLE_SLOTS;
    assign grown_bits = {prefix_bits_reg[pcbd_pkg::MAX_CODE_LEN-2:0], s1_bit_value_reg};
    assign grown_len  = prefix_len_reg + pcbd_pkg::PLEN_W'(1);

    always_comb
    begin
        wr        = '0;
        wr.write  = fire && is_write && in_range;
        wr.clear  = fire && is_clear;
        wr.addr   = pcbd_pkg::SLOT_W'(s1_slot_index_reg);
        wr.code   = pcbd_pkg::CMP_W'(s1_entry_code_reg);
        wr.length = s1_entry_length_reg;
        wr.symbol = s1_entry_symbol_reg;
        wr.used   = s1_entry_valid_reg;
    end

    pcbd_slot_table u_table
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .look_bits (pcbd_pkg::CMP_W'(grown_bits)),
        .look_len  (pcbd_pkg::LCMP_W'(grown_len)),
        .match     (match),
        .slot_sym  (slot_sym)
    );

    assign hit      = |match;
    assign overflow = !hit && (grown_len >= pcbd_pkg::PLEN_W'(pcbd_pkg::MAX_CODE_LEN));

    always_comb
    begin
        ctl.valid    = fire && is_decode && (hit || overflow);
        ctl.overflow = fire && is_decode && overflow;
    end

    always_comb
    begin
        prefix_bits_next = prefix_bits_reg;
        prefix_len_next  = prefix_len_reg;
        if (fire && is_clear)
        begin
            prefix_bits_next = '0;
            prefix_len_next  = '0;
        end
        else if (fire && is_decode)
        begin
            if (hit || overflow)
            begin
                prefix_bits_next = '0;
                prefix_len_next  = '0;
            end
            else
            begin
                prefix_bits_next = grown_bits;
                prefix_len_next  = grown_len;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_bits_reg <= '0;
            prefix_len_reg  <= '0;
        end
        else
        begin
            prefix_bits_reg <= prefix_bits_next;
            prefix_len_reg  <= prefix_len_next;
        end
    end

    pcbd_pick u_pick
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .ctl       (ctl),
        .match     (match),
        .slot_sym  (slot_sym),
        .out_valid (out_valid),
        .symbol    (symbol),
        .status    (status)
    );

`ifndef ASSERT_OFF
    a_overflow_symbol_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> symbol == '0)
        else $error("overflow result carries a nonzero symbol");

    a_prefix_bound: assert property (@(posedge clk) disable iff (!rst_n)
        prefix_len_reg < pcbd_pkg::PLEN_W'(pcbd_pkg::MAX_CODE_LEN))
        else $error("prefix length reached the maximum code length");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while the output is free");

    a_result_clears_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        fire && is_decode && (hit || overflow) |=> prefix_len_reg == '0)
        else $error("prefix not cleared after a result");

    a_clear_op: assert property (@(posedge clk) disable iff (!rst_n)
        fire && is_clear |=> prefix_len_reg == '0 && prefix_bits_reg == '0)
        else $error("clear left a nonzero prefix");
`endif

endmodule

>>> hw/rtl/pcbd_slot_table.sv
module pcbd_slot_table
(
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  pcbd_pkg::table_wr_t                              wr,
    input  logic [pcbd_pkg::CMP_W-1:0]                       look_bits,
    input  logic [pcbd_pkg::LCMP_W-1:0]                      look_len,
    output logic [pcbd_pkg::SLOTS_PAD-1:0]                   match,
    output logic [pcbd_pkg::SLOTS_PAD-1:0][pcbd_pkg::SYM_W-1:0] slot_sym
);

    logic [pcbd_pkg::TABLE_SLOTS-1:0] used_reg;
    logic [pcbd_pkg::CMP_W-1:0]       code_reg [pcbd_pkg::TABLE_SLOTS];
    logic [pcbd_pkg::ELEN_W-1:0]      len_reg  [pcbd_pkg::TABLE_SLOTS];
    logic [pcbd_pkg::SYM_W-1:0]       sym_reg  [pcbd_pkg::TABLE_SLOTS];
    logic [pcbd_pkg::CMP_W-1:0]       wr_code_masked;

    // Bits above the code length are dropped on the way in, so a lookup is a
    // plain equality against the running prefix.
    always_comb
    begin
        for (int i = 0; i < pcbd_pkg::CMP_W; i++)
        begin
            wr_code_masked[i] = wr.code[i] & (i < int'(wr.length));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (wr.clear)
        begin
            used_reg <= '0;
        end
        else if (wr.write)
        begin
            used_reg[wr.addr] <= wr.used;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.write)
        begin
            code_reg[wr.addr] <= wr_code_masked;
            len_reg[wr.addr]  <= wr.length;
            sym_reg[wr.addr]  <= wr.symbol;
        end
    end

    for (genvar i = 0; i < pcbd_pkg::SLOTS_PAD; i++)
    begin : g_cell
        if (i < pcbd_pkg::TABLE_SLOTS)
        begin : g_live
            assign match[i] = used_reg[i]
                && (pcbd_pkg::LCMP_W'(len_reg[i]) == look_len)
                && (code_reg[i] == look_bits);
            assign slot_sym[i] = sym_reg[i];
        end
        else
        begin : g_pad
            assign match[i]    = 1'b0;
            assign slot_sym[i] = '0;
        end
    end

endmodule

>>> hw/rtl/pcbd_pick.sv
module pcbd_pick
(
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  logic                                                 advance,
    input  pcbd_pkg::res_ctl_t                                   ctl,
    input  logic [pcbd_pkg::SLOTS_PAD-1:0]                       match,
    input  logic [pcbd_pkg::SLOTS_PAD-1:0][pcbd_pkg::SYM_W-1:0]  slot_sym,
    output logic                                                 out_valid,
    output logic [pcbd_pkg::SYM_W-1:0]                           symbol,
    output logic                                                 status
);

    localparam int GS = pcbd_pkg::GROUP_SIZE;
    localparam int NG = pcbd_pkg::NUM_GROUPS;

    logic [NG-1:0]                     grp_hit_next;
    logic [NG-1:0][pcbd_pkg::SYM_W-1:0] grp_sym_next;
    logic [NG-1:0]                     grp_hit_reg;
    logic [NG-1:0][pcbd_pkg::SYM_W-1:0] grp_sym_reg;
    logic                              s2_valid_reg;
    logic                              s2_overflow_reg;
    logic [pcbd_pkg::SYM_W-1:0]        sym_sel;
    logic [pcbd_pkg::SYM_W-1:0]        symbol_next;
    logic                              out_valid_reg;
    logic [pcbd_pkg::SYM_W-1:0]        symbol_reg;
    logic                              status_reg;

    // Within each group the highest matching slot is the only one with no
    // match above it, so the select lines are one-hot and can be OR-ed.
    always_comb
    begin
        grp_hit_next = '0;
        grp_sym_next = '0;
        for (int g = 0; g < NG; g++)
        begin
            grp_hit_next[g] = |match[g*GS +: GS];
            for (int j = 0; j < GS; j++)
            begin
                if (match[g*GS + j] && !(|(match[g*GS +: GS] >> (j + 1))))
                begin
                    grp_sym_next[g] = grp_sym_next[g] | slot_sym[g*GS + j];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg    <= 1'b0;
            s2_overflow_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg    <= ctl.valid;
            s2_overflow_reg <= ctl.overflow;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            grp_hit_reg <= grp_hit_next;
            grp_sym_reg <= grp_sym_next;
        end
    end

    always_comb
    begin
        sym_sel = '0;
        for (int g = 0; g < NG; g++)
        begin
            if (grp_hit_reg[g] && !(|(grp_hit_reg >> (g + 1))))
            begin
                sym_sel = sym_sel | grp_sym_reg[g];
            end
        end
        symbol_next = s2_overflow_reg ? '0 : sym_sel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            symbol_reg <= symbol_next;
            status_reg <= s2_overflow_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign symbol    = symbol_reg;
    assign status    = status_reg;

endmodule

>>> sim/pcbd_decode_check.sv
module pcbd_decode_check
    import pcbd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [1:0]          opcode,
    input  logic [INDEX_W-1:0]  slot_index,
    input  logic [CODE_W-1:0]   entry_code,
    input  logic [ELEN_W-1:0]   entry_length,
    input  logic [SYM_W-1:0]    entry_symbol,
    input  logic                entry_valid,
    input  logic                bit_value,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [SYM_W-1:0]    symbol,
    input  logic                status,
    output int                  mismatches,
    output int                  pending
);

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             status;
    } decode_result_t;

    // Private copy of the code table and the running prefix.
    logic              tbl_used [TABLE_SLOTS];
    logic [CODE_W-1:0] tbl_code [TABLE_SLOTS];
    logic [ELEN_W-1:0] tbl_len  [TABLE_SLOTS];
    logic [SYM_W-1:0]  tbl_sym  [TABLE_SLOTS];
    logic [63:0]       prefix_bits;
    int unsigned       prefix_len;

    decode_result_t expected_symbols [$];
    decode_result_t got;
    decode_result_t want;
    logic           hit;
    logic [SYM_W-1:0] hit_sym;
    logic [63:0]    prefix_mask;
    int             fail_count = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_SLOTS; i++)
                tbl_used[i] = 1'b0;
            prefix_bits = '0;
            prefix_len  = 0;
            expected_symbols.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = '{symbol: symbol, status: status};
                if (expected_symbols.size() == 0)
                begin
                    $display("%0t: result with nothing expected, actual symbol %02h status %0d",
                             $time, got.symbol, got.status);
                    fail_count++;
                end
                else
                begin
                    want = expected_symbols.pop_front();
                    if (got.symbol !== want.symbol)
                    begin
                        $display("%0t: symbol expected %02h actual %02h",
                                 $time, want.symbol, got.symbol);
                        fail_count++;
                    end
                    if (got.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                        fail_count++;
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                case (op_t'(opcode))
                    OP_WRITE:
                    begin
                        // The contents are kept even when the slot is marked unused.
                        if (slot_index < TABLE_SLOTS)
                        begin
                            tbl_code[slot_index] = entry_code;
                            tbl_len[slot_index]  = entry_length;
                            tbl_sym[slot_index]  = entry_symbol;
                            tbl_used[slot_index] = entry_valid;
                        end
                    end
                    OP_CLEAR:
                    begin
                        for (int i = 0; i < TABLE_SLOTS; i++)
                            tbl_used[i] = 1'b0;
                        prefix_bits = '0;
                        prefix_len  = 0;
                    end
                    OP_DECODE:
                    begin
                        prefix_bits = {prefix_bits[62:0], bit_value};
                        prefix_len++;
                        prefix_mask = (prefix_len >= 64) ? '1 : ((64'd1 << prefix_len) - 64'd1);
                        hit     = 1'b0;
                        hit_sym = '0;
                        // Ascending scan, so the highest matching slot is the one kept.
                        for (int i = 0; i < TABLE_SLOTS; i++)
                        begin
                            if (tbl_used[i] && (32'(tbl_len[i]) == prefix_len)
                                && (tbl_len[i] <= MAX_CODE_LEN)
                                && ((64'(tbl_code[i]) & prefix_mask)
                                    == (prefix_bits & prefix_mask)))
                            begin
                                hit     = 1'b1;
                                hit_sym = tbl_sym[i];
                            end
                        end
                        if (hit)
                        begin
                            expected_symbols.push_back('{symbol: hit_sym, status: 1'b0});
                            prefix_bits = '0;
                            prefix_len  = 0;
                        end
                        else if (prefix_len >= MAX_CODE_LEN)
                        begin
                            expected_symbols.push_back('{symbol: '0, status: 1'b1});
                            prefix_bits = '0;
                            prefix_len  = 0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        mismatches <= fail_count;
        pending    <= expected_symbols.size();
    end

endmodule

>>> sim/tb.sv
module tb;
    import pcbd_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int TOTAL_ITEMS = 1350;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_AT     = 800;
    localparam int HOLD_LEN    = 300;
    localparam int DRAIN       = 16;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         opcode;
    logic [INDEX_W-1:0] slot_index;
    logic [CODE_W-1:0]  entry_code;
    logic [ELEN_W-1:0]  entry_length;
    logic [SYM_W-1:0]   entry_symbol;
    logic               entry_valid;
    logic               bit_value;
    logic               out_valid;
    logic               out_stall;
    logic [SYM_W-1:0]   symbol;
    logic               status;
    int                 mismatches;
    int                 pending;

    int          items_sent = 0;
    int          burst_left = 1;
    int          cycles     = 0;

    // Current code set for well-formed bit streams.
    logic [31:0] cw_bits [16];
    int          cw_len  [16];
    int          n_codes;

    prefix_code_bit_decoder_unit dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .slot_index   (slot_index),
        .entry_code   (entry_code),
        .entry_length (entry_length),
        .entry_symbol (entry_symbol),
        .entry_valid  (entry_valid),
        .bit_value    (bit_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .symbol       (symbol),
        .status       (status)
    );

    pcbd_decode_check u_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .slot_index   (slot_index),
        .entry_code   (entry_code),
        .entry_length (entry_length),
        .entry_symbol (entry_symbol),
        .entry_valid  (entry_valid),
        .bit_value    (bit_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .symbol       (symbol),
        .status       (status),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: changing stall patterns, plus one long hold-off that backs the block up.
    initial
    begin
        int rx_cycle;
        int hold_left;
        int mode;
        int span;
        int period;
        int duty;
        bit held;
        rx_cycle  = 0;
        hold_left = 0;
        held      = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            mode   = $urandom_range(0, 3);
            span   = $urandom_range(20, 120);
            period = $urandom_range(2, 9);
            duty   = $urandom_range(1, period - 1);
            repeat (span)
            begin
                @(posedge clk);
                rx_cycle++;
                if (!held && rx_cycle >= HOLD_AT)
                begin
                    held      = 1'b1;
                    hold_left = HOLD_LEN;
                    out_stall <= 1'b1;
                end
                else if (hold_left > 0)
                begin
                    hold_left--;
                    out_stall <= 1'b1;
                end
                else
                begin
                    case (mode)
                        0: out_stall <= 1'b0;
                        1: out_stall <= ($urandom_range(0, 3) == 0);
                        2: out_stall <= ($urandom_range(0, 1) == 0);
                        default: out_stall <= ((rx_cycle % period) < duty);
                    endcase
                end
            end
        end
    end

    task automatic send_beat(input logic [1:0] op, input logic [INDEX_W-1:0] idx,
                             input logic [CODE_W-1:0] code, input logic [ELEN_W-1:0] len,
                             input logic [SYM_W-1:0] sym, input logic ev, input logic b);
        int gap;
        in_valid     <= 1'b1;
        opcode       <= op;
        slot_index   <= idx;
        entry_code   <= code;
        entry_length <= len;
        entry_symbol <= sym;
        entry_valid  <= ev;
        bit_value    <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (op != OP_UNUSED)
            items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap)
                    @(posedge clk);
            end
        end
    endtask

    task automatic write_slot(input logic [INDEX_W-1:0] idx, input logic [CODE_W-1:0] code,
                              input logic [ELEN_W-1:0] len, input logic [SYM_W-1:0] sym,
                              input logic ev);
        send_beat(OP_WRITE, idx, code, len, sym, ev, 1'($urandom));
    endtask

    // Fields other than the bit carry random junk, which the block must ignore.
    task automatic decode_bit(input logic b);
        send_beat(OP_DECODE, 8'($urandom), 32'($urandom), 6'($urandom), 8'($urandom),
                  1'($urandom), b);
    endtask

    task automatic clear_all();
        send_beat(OP_CLEAR, 8'($urandom), 32'($urandom), 6'($urandom), 8'($urandom),
                  1'($urandom), 1'($urandom));
    endtask

    task automatic idle_op();
        send_beat(OP_UNUSED, 8'($urandom), 32'($urandom), 6'($urandom), 8'($urandom),
                  1'($urandom), 1'($urandom));
    endtask

    // Canonical prefix code with ascending lengths, loaded into random slots.
    task automatic load_code_table();
        int target;
        int l;
        int nxt;
        int k;
        logic [63:0] c;
        logic [31:0] code_word;
        target  = $urandom_range(2, 16);
        l       = $urandom_range(1, 4);
        c       = '0;
        n_codes = 0;
        for (k = 0; k < target; k++)
        begin
            if (k > 0)
            begin
                nxt = l + $urandom_range(0, 1);
                if (k == target - 1 && $urandom_range(0, 4) == 0)
                    nxt = ($urandom_range(0, 1) == 0) ? MAX_CODE_LEN : $urandom_range(l, 31);
                c = (c + 64'd1) << (nxt - l);
                if ((c >> nxt) != 0)
                    break;
                l = nxt;
            end
            cw_bits[n_codes] = c[31:0];
            cw_len[n_codes]  = l;
            n_codes++;
        end
        for (k = 0; k < n_codes; k++)
        begin
            // Junk above the code length must not take part in matching.
            code_word = cw_bits[k];
            if (cw_len[k] < 32)
                code_word = code_word | (32'($urandom) << cw_len[k]);
            write_slot(8'($urandom), code_word, 6'(cw_len[k]), 8'($urandom),
                       $urandom_range(0, 19) != 0);
            if ($urandom_range(0, 4) == 0)
                write_slot(8'($urandom), code_word, 6'(cw_len[k]), 8'($urandom), 1'b1);
        end
    endtask

    task automatic decode_words(input int count);
        int k;
        repeat (count)
        begin
            k = $urandom_range(0, n_codes - 1);
            for (int b = cw_len[k] - 1; b >= 0; b--)
                decode_bit(cw_bits[k][b]);
            if ($urandom_range(0, 19) == 0)
                decode_bit(1'($urandom));
        end
    endtask

    initial
    begin
        int pick;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        opcode       = OP_WRITE;
        slot_index   = '0;
        entry_code   = '0;
        entry_length = '0;
        entry_symbol = '0;
        entry_valid  = 1'b0;
        bit_value    = 1'b0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, duplicates, masked upper bits, unusable lengths, clear.
        write_slot(8'd0, 32'h0000_0000, 6'd1, 8'h00, 1'b1);
        write_slot(8'd255, 32'hFFFF_FFFF, 6'd32, 8'hFF, 1'b1);
        write_slot(8'd1, 32'h0000_0002, 6'd2, 8'hA5, 1'b0);
        write_slot(8'd2, 32'hFFFF_FFFE, 6'd2, 8'h5A, 1'b1);
        write_slot(8'd3, 32'h0000_0002, 6'd2, 8'h3C, 1'b1);
        write_slot(8'd4, 32'h0000_0000, 6'd0, 8'h11, 1'b1);
        write_slot(8'd5, 32'h0000_0001, 6'd63, 8'h22, 1'b1);
        write_slot(8'd6, 32'h0000_0007, 6'd33, 8'h33, 1'b1);
        decode_bit(1'b0);
        decode_bit(1'b1);
        decode_bit(1'b0);
        idle_op();
        write_slot(8'd0, 32'h0000_0000, 6'd1, 8'h77, 1'b0);
        decode_bit(1'b1);
        decode_bit(1'b1);
        decode_bit(1'b0);
        clear_all();
        decode_bit(1'b1);
        decode_bit(1'b0);
        write_slot(8'd1, 32'h0000_0001, 6'd1, 8'h81, 1'b1);
        decode_bit(1'b1);
        clear_all();

        while (items_sent < TOTAL_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                if ($urandom_range(0, 4) != 0)
                    clear_all();
                load_code_table();
                decode_words($urandom_range(4, 30));
            end
            else if (pick < 80)
            begin
                if ($urandom_range(0, 1) == 0)
                    clear_all();
                repeat ($urandom_range(33, 70))
                    decode_bit(1'($urandom));
            end
            else if (pick < 92)
            begin
                repeat ($urandom_range(1, 6))
                    write_slot(8'($urandom), 32'($urandom), 6'($urandom), 8'($urandom),
                               1'($urandom));
            end
            else if (pick < 96)
                clear_all();
            else
                idle_op();
        end
        in_valid <= 1'b0;
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN)
            @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
